>>> sv/stream_duplicate_filter_assert.svh
// Assertion macros for the stream duplicate filter.
// Included by the top level; no other dependencies.
`ifndef STREAM_DUPLICATE_FILTER_ASSERT_SVH
`define STREAM_DUPLICATE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SDF_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("sdf assertion failed");

// Next-cycle implication, disabled during reset.
`define SDF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("sdf assertion failed");

`endif

>>> sv/sdf_pkg.sv
// Shared types and constants for the stream duplicate filter.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in_set;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] echo_value;
    logic               is_unique;
    logic               dropped_full;
    logic [6:0]         distinct_count;
    logic               set_done;
  } out_item_t;

  // Handshake from the input queue to the search engine.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

endpackage

>>> sv/sdf_inq.sv
// Front end: two-entry input queue that takes beats while the back end searches.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_inq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  sdf_pkg::in_item_t in_data,
  output sdf_pkg::q_head_t  head,
  input  logic              take
);
  import sdf_pkg::*;

  in_item_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = take && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> sv/sdf_scan.sv
// Back end: distinct-value store, one-entry-per-cycle linear search, result register.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  sdf_pkg::q_head_t   head,
  output logic               take,
  output logic               empty,
  input  logic               pop,
  output sdf_pkg::out_item_t out_data
);
  import sdf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic signed [31:0] store_mem [CAPACITY];
  logic signed [31:0] rd_data_r;

  logic [1:0]       st_r, st_nxt;
  in_item_t         cur_r, cur_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic             found_r, found_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        res_r, res_nxt;

  logic             issue, match, load;
  logic             is_new, room;
  logic [CNT_W-1:0] cnt_after;

  assign empty    = !ov_r;
  assign out_data = res_r;

  assign issue  = (idx_r < cnt_r);
  assign match  = cmp_v_r && (rd_data_r == cur_r.value);
  assign load   = (st_r == ST_DONE) && (!ov_r || pop);
  assign is_new = !found_r;
  assign room   = (cnt_r < CNT_W'(CAPACITY));
  assign cnt_after = cnt_r + {{(CNT_W-1){1'b0}}, is_new && room};

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    cmp_v_nxt = 1'b0;
    found_nxt = found_r;
    ov_nxt    = (ov_r && pop) ? 1'b0 : ov_r;
    res_nxt   = res_r;
    take      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (head.valid) begin
          take    = 1'b1;
          cur_nxt = head.item;
          idx_nxt = '0;
          st_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          found_nxt = 1'b1;
          st_nxt    = ST_DONE;
        end else if (!issue && !cmp_v_r) begin
          found_nxt = 1'b0;
          st_nxt    = ST_DONE;
        end else begin
          cmp_v_nxt = issue;
          if (issue) begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (load) begin
          res_nxt.echo_value     = cur_r.value;
          res_nxt.is_unique      = is_new && room;
          res_nxt.dropped_full   = is_new && !room;
          res_nxt.distinct_count = 7'(cnt_after);
          res_nxt.set_done       = cur_r.last_in_set;
          ov_nxt  = 1'b1;
          cnt_nxt = cur_r.last_in_set ? '0 : cnt_after;
          st_nxt  = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      cmp_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      cmp_v_r <= cmp_v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
  end

  // Store: one write port (append), one registered read port (scan).
  always_ff @(posedge clk) begin
    if (load && is_new && room) begin
      store_mem[cnt_r[ADDR_W-1:0]] <= cur_r.value;
    end
    rd_data_r <= store_mem[idx_r[ADDR_W-1:0]];
  end

endmodule

>>> sv/stream_duplicate_filter.sv
// Stream duplicate filter: order-preserving duplicate removal over sets of values.
// Top level; depends on sdf_pkg, sdf_inq, sdf_scan and stream_duplicate_filter_assert.svh.
//
// Usage:
//  - Input channel: drive in_data (value, last_in_set) with push; a beat is taken
//    on a rising edge with push high and full low. Up to two beats are buffered.
//  - Result channel: while empty is low, out_data holds the oldest result; it is
//    taken on a rising edge with pop high. One result per input beat, in order.
//  - Each value is searched against the distinct values stored for the current
//    set, one stored entry per cycle from a single-port store read. A new value is
//    appended (is_unique) or, with all CAPACITY entries in use, flagged
//    dropped_full. A last_in_set beat empties the store after its result.
//  - Steps per item on a miss: take, one read per stored entry, last compare, miss
//    decision, result load; a match ends the search early. The linear search sets
//    the rate; the engine handles one item at a time, beats wait in the queue.
//  - A stalled result register holds the search engine at its result load step; the
//    input queue still takes beats until it fills.
//  - Reset (rst_n low, synchronous): queue, result valid flag and store count clear;
//    store contents need no clearing since only entries below the count are read.
`timescale 1ns / 1ps

module stream_duplicate_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sdf_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output sdf_pkg::out_item_t out_data
);
  import sdf_pkg::*;

  q_head_t head;
  logic    take;

  // Front: accept beats into a short queue.
  sdf_inq u_inq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .head    (head),
    .take    (take)
  );

  // Back: search the store, update it, present the result.
  sdf_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .take     (take),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

`include "stream_duplicate_filter_assert.svh"

  // A result is never both stored and dropped.
  `SDF_ASSERT_NOW(a_uniq_xor_drop, clk, rst_n, !empty, !(out_data.is_unique && out_data.dropped_full))
  // A drop only happens with the store at capacity.
  `SDF_ASSERT_NOW(a_drop_at_cap, clk, rst_n, !empty && out_data.dropped_full, out_data.distinct_count == 7'(CAPACITY))
  // A stored value means the count is at least one.
  `SDF_ASSERT_NOW(a_uniq_count, clk, rst_n, !empty && out_data.is_unique, out_data.distinct_count != 7'd0)
  // The queue only reports full while it has a head beat to offer.
  `SDF_ASSERT_NOW(a_full_has_head, clk, rst_n, full, head.valid)

endmodule
